>>> hw/rtl/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table.
// No dependencies.
package dvrt_pkg;

  localparam int TableEntries = 32;
  localparam int RouterIds    = 16;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = $clog2(TableEntries + 1);

  localparam logic [4:0] Unreachable = 5'd16;
  localparam logic [4:0] HopCost     = 5'd1;
  localparam logic [5:0] MaxPrefix   = 6'd32;

  localparam logic [2:0] OpInstall   = 3'd0;
  localparam logic [2:0] OpReceive   = 3'd1;
  localparam logic [2:0] OpAdvertise = 3'd2;
  localparam logic [2:0] OpLinkDown  = 3'd3;
  localparam logic [2:0] OpClose     = 3'd4;

  localparam logic [3:0] StNoChange = 4'd0;
  localparam logic [3:0] StNew      = 4'd1;
  localparam logic [3:0] StSameHop  = 4'd2;
  localparam logic [3:0] StBetter   = 4'd3;
  localparam logic [3:0] StFull     = 4'd4;
  localparam logic [3:0] StEntry    = 4'd5;
  localparam logic [3:0] StEmpty    = 4'd6;
  localparam logic [3:0] StLinkDown = 4'd7;
  localparam logic [3:0] StCycle    = 4'd8;
  localparam logic [3:0] StInstall  = 4'd9;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  neighbour;
    logic [31:0] net_address;
    logic [5:0]  prefix_len;
    logic [4:0]  adv_metric;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] route_address;
    logic [5:0]  route_prefix;
    logic [4:0]  route_metric;
    logic [3:0]  route_next_hop;
    logic        route_direct;
    logic [5:0]  change_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  prefix;
    logic [4:0]  metric;
    logic [3:0]  hop;
    logic        direct;
    logic        changed;
  } route_t;

  localparam int RouteW = $bits(route_t);

  // controller to datapath
  typedef struct packed {
    logic            load;      // capture input item
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic            eval;      // compare read entry to key
    logic            emit_adv;  // build advertise result from read entry
    logic            poison;    // rewrite read entry for link down
    logic            clear;     // rewrite read entry for close cycle
    logic            finish;    // build final single result and write back
    logic            last_adv;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [CntW-1:0] entry_count;
  } stat_t;

endpackage

>>> hw/rtl/dvrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dvrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/dvrt_datapath.sv
// Datapath: input capture, table RAM, match search, counters and result register.
// Depends on dvrt_pkg and dvrt_ram.
module dvrt_datapath import dvrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t res
);

  in_item_t        key;
  logic [5:0]      pfx_sat;
  logic [4:0]      nm;
  logic            nb_ok;
  logic            found;
  logic [IdxW-1:0] found_idx;
  route_t          found_r;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] entry_count;
  logic            rd_v;
  logic [IdxW-1:0] rd_idx_q;
  route_t          rd_r;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  route_t          wr_data;
  logic            via_nb;
  logic [5:0]      adv_sum;

  assign stat.op          = key.operation;
  assign stat.entry_count = entry_count;

  assign pfx_sat = (in_item.prefix_len > MaxPrefix) ? MaxPrefix : in_item.prefix_len;
  assign adv_sum = {1'b0, key.adv_metric} + {1'b0, HopCost};
  assign nm      = (adv_sum > {1'b0, Unreachable}) ? Unreachable : adv_sum[4:0];
  assign nb_ok   = 32'(key.neighbour) < RouterIds;
  assign via_nb  = nb_ok && !rd_r.direct && rd_r.hop == key.neighbour;

  dvrt_ram #(.Width(RouteW), .Depth(TableEntries)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data,
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_idx), .rd_data(rd_r)
  );

  // write-back of the final single-result operations
  logic            fin_we;
  logic [IdxW-1:0] fin_addr;
  route_t          fin_r;
  out_item_t       fin_res;
  logic            fin_inc;

  always_comb begin
    fin_we   = 1'b0;
    fin_addr = found_idx;
    fin_r    = found_r;
    fin_inc  = 1'b0;
    fin_res  = '0;
    fin_res.last = 1'b1;
    case (key.operation)
      OpInstall: begin
        fin_r = '{addr: key.net_address, prefix: key.prefix_len, metric: '0,
                  hop: '0, direct: 1'b1, changed: 1'b0};
        if (!found && entry_count >= CntW'(TableEntries)) begin
          fin_res.status = StFull;
        end else begin
          fin_we = 1'b1;
          if (!found) begin
            fin_addr = entry_count[IdxW-1:0];
            fin_inc  = 1'b1;
          end
          fin_res.status = StInstall;
        end
        fin_res.route_address = key.net_address;
        fin_res.route_prefix  = key.prefix_len;
        fin_res.route_direct  = 1'b1;
      end
      OpReceive: begin
        fin_res.route_address  = key.net_address;
        fin_res.route_prefix   = key.prefix_len;
        fin_res.route_metric   = nm;
        fin_res.route_next_hop = key.neighbour;
        fin_res.status         = StNoChange;
        if (nb_ok && !found) begin
          if (nm < Unreachable) begin
            if (entry_count >= CntW'(TableEntries)) begin
              fin_res.status = StFull;
            end else begin
              fin_we   = 1'b1;
              fin_addr = entry_count[IdxW-1:0];
              fin_inc  = 1'b1;
              fin_r = '{addr: key.net_address, prefix: key.prefix_len, metric: nm,
                        hop: key.neighbour, direct: 1'b0, changed: 1'b1};
              fin_res.status = StNew;
            end
          end
        end else if (nb_ok) begin
          if (!found_r.direct && found_r.hop == key.neighbour) begin
            if (found_r.metric != nm) begin
              fin_r.metric = nm;
              fin_r.changed = 1'b1;
              fin_we = 1'b1;
              fin_res.status = StSameHop;
            end
          end else if (!found_r.direct && nm < found_r.metric) begin
            fin_r.metric = nm;
            fin_r.hop = key.neighbour;
            fin_r.changed = 1'b1;
            fin_we = 1'b1;
            fin_res.status = StBetter;
          end
          fin_res.route_address  = fin_r.addr;
          fin_res.route_prefix   = fin_r.prefix;
          fin_res.route_metric   = fin_r.metric;
          fin_res.route_next_hop = fin_r.hop;
          fin_res.route_direct   = fin_r.direct;
        end
      end
      OpAdvertise: fin_res.status = StEmpty;
      OpLinkDown: begin
        fin_res.status = StLinkDown;
        fin_res.change_count = 6'(cnt);
      end
      OpClose: begin
        fin_res.status = StCycle;
        fin_res.change_count = 6'(cnt);
      end
      default: fin_res.status = StNoChange;
    endcase
  end

  // scan write-back
  route_t scan_r;
  logic   scan_we;
  always_comb begin
    scan_r  = rd_r;
    scan_we = 1'b0;
    if (cmd.poison && rd_v && via_nb) begin
      scan_r.metric  = Unreachable;
      scan_r.changed = 1'b1;
      scan_we = 1'b1;
    end
    if (cmd.clear && rd_v && rd_r.changed) begin
      scan_r.changed = 1'b0;
      scan_we = 1'b1;
    end
    wr_en   = cmd.finish ? fin_we : scan_we;
    wr_addr = cmd.finish ? fin_addr : rd_idx_q;
    wr_data = cmd.finish ? fin_r : scan_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      rd_v        <= 1'b0;
    end else begin
      rd_v <= cmd.rd_en;
      if (cmd.finish && fin_inc) entry_count <= entry_count + 1'b1;
    end
    rd_idx_q <= cmd.rd_idx;
    if (cmd.load) begin
      key   <= '{operation: in_item.operation, neighbour: in_item.neighbour,
                 net_address: in_item.net_address, prefix_len: pfx_sat,
                 adv_metric: in_item.adv_metric};
      found <= 1'b0;
      cnt   <= '0;
    end
    if (cmd.eval && rd_v && !found && rd_r.addr == key.net_address
        && rd_r.prefix == key.prefix_len) begin
      found     <= 1'b1;
      found_idx <= rd_idx_q;
      found_r   <= rd_r;
    end
    if ((cmd.poison && rd_v && via_nb) || (cmd.clear && rd_v && rd_r.changed))
      cnt <= cnt + 1'b1;
    if (cmd.emit_adv) begin
      res.status         <= StEntry;
      res.route_address  <= rd_r.addr;
      res.route_prefix   <= rd_r.prefix;
      res.route_metric   <= via_nb ? Unreachable : rd_r.metric;
      res.route_next_hop <= rd_r.hop;
      res.route_direct   <= rd_r.direct;
      res.change_count   <= '0;
      res.last           <= cmd.last_adv;
    end else if (cmd.finish) begin
      res <= fin_res;
    end
  end

endmodule

>>> hw/rtl/dvrt_ctrl.sv
// Controller: sequences the table scan for each operation and the output handshake.
// Depends on dvrt_pkg.
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN, S_ADV, S_WAIT} state_t;

  state_t          state;
  logic [CntW-1:0] idx;   // next entry to read
  logic            adv_more;

  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmd = '0;
    cmd.load     = (state == S_IDLE) && in_valid && !out_valid;
    cmd.rd_idx   = idx[IdxW-1:0];
    cmd.eval     = (state == S_SCAN) || (state == S_DRAIN);
    cmd.poison   = cmd.eval && stat.op == OpLinkDown;
    cmd.clear    = cmd.eval && stat.op == OpClose;
    cmd.finish   = (state == S_FIN);
    adv_more     = idx < stat.entry_count;
    cmd.rd_en    = ((state == S_SCAN) && adv_more) ||
                   ((state == S_ADV) && adv_more && (!out_valid || !out_stall));
    cmd.emit_adv = (state == S_WAIT) && (!out_valid || !out_stall);
    cmd.last_adv = !adv_more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.load) begin
          idx  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.op == OpAdvertise) begin
            state <= (stat.entry_count == '0) ? S_FIN : S_ADV;
          end else if (adv_more && (stat.op == OpInstall || stat.op == OpReceive
                       || stat.op == OpLinkDown || stat.op == OpClose)) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        // spare cycle: the last read was already evaluated in the final scan cycle
        S_DRAIN: state <= S_FIN;
        S_FIN: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_ADV: if (cmd.rd_en) begin
          idx   <= idx + 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (cmd.emit_adv) begin
          out_valid <= 1'b1;
          state <= adv_more ? S_ADV : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/distance_vector_route_table.sv
// Distance-vector route table top level: controller plus datapath.
// Each operation gives one result after its table scan; advertise instead gives one
// result per entry (a single empty result on an empty table), reading each next entry
// only once the previous result is accepted. One item at a time: the single RAM read
// port scans one entry a cycle for the others; in_stall holds off the next item.
// Reset (rst, synchronous): empties the table; entry contents stay undefined.
module distance_vector_route_table import dvrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  dvrt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  dvrt_datapath u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .res(out_data)
  );

endmodule
